// ----- design/spcr_pkg.sv -----
package spcr_pkg;

  localparam int CompBits   = 16;
  localparam int NumComp    = 3;
  localparam int VecBits    = NumComp * CompBits;
  localparam int ScalarBits = 16;
  localparam int RadBits    = 50;
  localparam int RootBits   = RadBits / 2;
  localparam int RemBits    = RootBits + 1;
  localparam int SqrtStages = RootBits;
  localparam int QuotBits   = 15;
  localparam int DivStages  = QuotBits;
  localparam int NormShift  = 22;
  localparam int DivRemBits = CompBits + NormShift;
  localparam int DivCmpBits = RootBits + QuotBits;
  localparam int SpeedBits  = RootBits + 2;
  localparam int SumBits    = RootBits + 1;
  localparam logic [QuotBits-1:0] NormOne = QuotBits'(16384);

  typedef enum logic [1:0] {
    CfgAdjust = 2'd0,
    CfgMode   = 2'd1,
    CfgBounce = 2'd2
  } cfg_reg_e;

  typedef logic [CompBits-1:0] mag_t;
  typedef logic [QuotBits-1:0] quot_t;

  typedef struct packed {
    logic                              valid;
    logic                              hit;
    logic [VecBits-1:0]                dir_a;
    logic [VecBits-1:0]                dir_b;
    logic [ScalarBits-1:0]             mass_a;
    logic [ScalarBits-1:0]             mass_b;
    logic [NumComp-1:0]                dneg;
    logic [NumComp-1:0][CompBits-1:0]  dmag;
    logic [SumBits-1:0]                sp;
  } side_t;

  function automatic logic signed [CompBits-1:0] comp(input logic [VecBits-1:0] v,
                                                      input int i);
    return $signed(v[i*CompBits +: CompBits]);
  endfunction

  function automatic mag_t comp_mag(input logic [VecBits-1:0] v, input int i);
    logic [CompBits-1:0] x;
    x = v[i*CompBits +: CompBits];
    return x[CompBits-1] ? mag_t'(-x) : x;
  endfunction

endpackage

// ----- design/spcr_front.sv -----
module spcr_front (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                en_i,
  input  logic                                                valid_i,
  input  logic [spcr_pkg::VecBits-1:0]                        pos_a_i,
  input  logic [spcr_pkg::VecBits-1:0]                        pos_b_i,
  input  logic [spcr_pkg::VecBits-1:0]                        dir_a_i,
  input  logic [spcr_pkg::VecBits-1:0]                        dir_b_i,
  input  logic [spcr_pkg::ScalarBits-1:0]                     radius_a_i,
  input  logic [spcr_pkg::ScalarBits-1:0]                     radius_b_i,
  input  logic [spcr_pkg::ScalarBits-1:0]                     mass_a_i,
  input  logic [spcr_pkg::ScalarBits-1:0]                     mass_b_i,
  input  logic [spcr_pkg::ScalarBits-1:0]                     adjustment_i,
  output spcr_pkg::side_t                                     side_o,
  output logic [spcr_pkg::NumComp-1:0][spcr_pkg::RadBits-1:0] rad_o
);

  localparam int D2Bits = 2 * spcr_pkg::CompBits + 2;
  localparam int V2Bits = 2 * spcr_pkg::CompBits;
  localparam int SBits  = 2 * spcr_pkg::ScalarBits + 1;

  // stage 1
  logic                                                  s1_valid_q;
  logic [spcr_pkg::NumComp-1:0]                          s1_dneg_q, s1_dneg_d;
  logic [spcr_pkg::NumComp-1:0][spcr_pkg::CompBits-1:0]  s1_dmag_q, s1_dmag_d;
  logic [D2Bits-1:0]                                     s1_d2_q, s1_d2_d;
  logic [V2Bits-1:0]                                     s1_va2_q, s1_va2_d;
  logic [V2Bits-1:0]                                     s1_vb2_q, s1_vb2_d;
  logic [SBits-1:0]                                      s1_s_q, s1_s_d;
  logic [spcr_pkg::VecBits-1:0]                          s1_dir_a_q, s1_dir_b_q;
  logic [spcr_pkg::ScalarBits-1:0]                       s1_mass_a_q, s1_mass_b_q;

  // stage 2
  spcr_pkg::side_t                                       side_q, side_d;
  logic [spcr_pkg::NumComp-1:0][spcr_pkg::RadBits-1:0]   rad_q, rad_d;

  always_comb begin
    logic signed [spcr_pkg::CompBits-1:0] ca;
    logic signed [spcr_pkg::CompBits-1:0] cb;
    logic signed [spcr_pkg::CompBits:0] diff;
    logic [spcr_pkg::CompBits:0]        mag;
    logic [V2Bits-1:0]                  sq;
    spcr_pkg::mag_t                     am;
    spcr_pkg::mag_t                     bm;
    s1_d2_d  = '0;
    s1_va2_d = '0;
    s1_vb2_d = '0;
    for (int i = 0; i < spcr_pkg::NumComp; i++) begin
      ca   = spcr_pkg::comp(pos_a_i, i);
      cb   = spcr_pkg::comp(pos_b_i, i);
      diff = $signed({ca[spcr_pkg::CompBits-1], ca})
           - $signed({cb[spcr_pkg::CompBits-1], cb});
      mag  = diff[spcr_pkg::CompBits] ? (spcr_pkg::CompBits+1)'(-diff)
                                      : (spcr_pkg::CompBits+1)'(diff);
      s1_dneg_d[i] = diff[spcr_pkg::CompBits];
      s1_dmag_d[i] = mag[spcr_pkg::CompBits-1:0];
      sq       = V2Bits'(s1_dmag_d[i]) * V2Bits'(s1_dmag_d[i]);
      s1_d2_d  = s1_d2_d + D2Bits'(sq);
      am       = spcr_pkg::comp_mag(dir_a_i, i);
      bm       = spcr_pkg::comp_mag(dir_b_i, i);
      s1_va2_d = s1_va2_d + V2Bits'(am) * V2Bits'(am);
      s1_vb2_d = s1_vb2_d + V2Bits'(bm) * V2Bits'(bm);
    end
    s1_s_d = SBits'(adjustment_i) * (SBits'(radius_a_i) + SBits'(radius_b_i));
  end

  always_comb begin
    logic [63:0] ss;
    ss = 64'(s1_s_q[SBits-2:0]) * 64'(s1_s_q[SBits-2:0]);
    side_d        = '0;
    side_d.valid  = s1_valid_q;
    side_d.hit    = s1_s_q[SBits-1] || (64'({s1_d2_q, 16'h0}) < ss);
    side_d.dir_a  = s1_dir_a_q;
    side_d.dir_b  = s1_dir_b_q;
    side_d.mass_a = s1_mass_a_q;
    side_d.mass_b = s1_mass_b_q;
    side_d.dneg   = s1_dneg_q;
    side_d.dmag   = s1_dmag_q;
    rad_d[0] = spcr_pkg::RadBits'({s1_d2_q, 16'h0});
    rad_d[1] = spcr_pkg::RadBits'({s1_va2_q, 16'h0});
    rad_d[2] = spcr_pkg::RadBits'({s1_vb2_q, 16'h0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_dneg_q   <= s1_dneg_d;
      s1_dmag_q   <= s1_dmag_d;
      s1_d2_q     <= s1_d2_d;
      s1_va2_q    <= s1_va2_d;
      s1_vb2_q    <= s1_vb2_d;
      s1_s_q      <= s1_s_d;
      s1_dir_a_q  <= dir_a_i;
      s1_dir_b_q  <= dir_b_i;
      s1_mass_a_q <= mass_a_i;
      s1_mass_b_q <= mass_b_i;
      rad_q       <= rad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_d;
    end
  end

  assign side_o = side_q;
  assign rad_o  = rad_q;

endmodule

// ----- design/spcr_sqrt3.sv -----
module spcr_sqrt3 (
  input  logic                                                 clk_i,
  input  logic                                                 en_i,
  input  logic [spcr_pkg::NumComp-1:0][spcr_pkg::RadBits-1:0]  rad_i,
  output logic [spcr_pkg::NumComp-1:0][spcr_pkg::RootBits-1:0] root_o
);

  localparam int Lanes = spcr_pkg::NumComp;
  localparam int Depth = spcr_pkg::SqrtStages;

  logic [spcr_pkg::RemBits-1:0]  rem_q  [Depth][Lanes];
  logic [spcr_pkg::RemBits-1:0]  rem_d  [Depth][Lanes];
  logic [spcr_pkg::RootBits-1:0] root_q [Depth][Lanes];
  logic [spcr_pkg::RootBits-1:0] root_d [Depth][Lanes];
  logic [spcr_pkg::RadBits-1:0]  rad_q  [Depth][Lanes];
  logic [spcr_pkg::RadBits-1:0]  rad_d  [Depth][Lanes];

  // one result bit per stage: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    logic [spcr_pkg::RemBits-1:0]  ri;
    logic [spcr_pkg::RootBits-1:0] oi;
    logic [spcr_pkg::RadBits-1:0]  di;
    logic [spcr_pkg::RemBits+1:0]  remx;
    logic [spcr_pkg::RemBits+1:0]  trial;
    for (int s = 0; s < Depth; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        if (s == 0) begin
          ri = '0;
          oi = '0;
          di = rad_i[l];
        end else begin
          ri = rem_q[s-1][l];
          oi = root_q[s-1][l];
          di = rad_q[s-1][l];
        end
        remx  = {ri, di[spcr_pkg::RadBits-1 -: 2]};
        trial = {1'b0, oi, 2'b01};
        if (remx >= trial) begin
          rem_d[s][l]  = spcr_pkg::RemBits'(remx - trial);
          root_d[s][l] = {oi[spcr_pkg::RootBits-2:0], 1'b1};
        end else begin
          rem_d[s][l]  = remx[spcr_pkg::RemBits-1:0];
          root_d[s][l] = {oi[spcr_pkg::RootBits-2:0], 1'b0};
        end
        rad_d[s][l] = di << 2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      root_o[l] = root_q[Depth-1][l];
    end
  end

endmodule

// ----- design/spcr_div3.sv -----
module spcr_div3 (
  input  logic                                                 clk_i,
  input  logic                                                 en_i,
  input  logic [spcr_pkg::NumComp-1:0][spcr_pkg::CompBits-1:0] num_i,
  input  logic [spcr_pkg::RootBits-1:0]                        den_i,
  output logic [spcr_pkg::NumComp-1:0][spcr_pkg::QuotBits-1:0] quot_o
);

  localparam int Lanes = spcr_pkg::NumComp;
  localparam int Depth = spcr_pkg::DivStages;

  logic [spcr_pkg::DivRemBits-1:0] rem_q [Depth][Lanes];
  logic [spcr_pkg::DivRemBits-1:0] rem_d [Depth][Lanes];
  spcr_pkg::quot_t                 quo_q [Depth][Lanes];
  spcr_pkg::quot_t                 quo_d [Depth][Lanes];
  logic [spcr_pkg::RootBits-1:0]   den_q [Depth];
  logic [spcr_pkg::RootBits-1:0]   den_d [Depth];

  // restoring division, one quotient bit per stage from the top
  always_comb begin
    logic [spcr_pkg::DivRemBits-1:0] ri;
    spcr_pkg::quot_t                 qi;
    logic [spcr_pkg::RootBits-1:0]   di;
    logic [spcr_pkg::DivCmpBits-1:0] sh;
    logic [spcr_pkg::DivCmpBits-1:0] rx;
    for (int s = 0; s < Depth; s++) begin
      di = (s == 0) ? den_i : den_q[s-1];
      den_d[s] = di;
      for (int l = 0; l < Lanes; l++) begin
        if (s == 0) begin
          ri = {num_i[l], {spcr_pkg::NormShift{1'b0}}};
          qi = '0;
        end else begin
          ri = rem_q[s-1][l];
          qi = quo_q[s-1][l];
        end
        sh = spcr_pkg::DivCmpBits'(di) << (spcr_pkg::QuotBits - 1 - s);
        rx = spcr_pkg::DivCmpBits'(ri);
        quo_d[s][l] = qi;
        if (rx >= sh) begin
          rem_d[s][l] = spcr_pkg::DivRemBits'(rx - sh);
          quo_d[s][l][spcr_pkg::QuotBits-1-s] = 1'b1;
        end else begin
          rem_d[s][l] = ri;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_d;
    end
  end

  // coincident centres give a zero normal
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (den_q[Depth-1] == '0) begin
        quot_o[l] = '0;
      end else if (quo_q[Depth-1][l] > spcr_pkg::NormOne) begin
        quot_o[l] = spcr_pkg::NormOne;
      end else begin
        quot_o[l] = quo_q[Depth-1][l];
      end
    end
  end

endmodule

// ----- design/spcr_back.sv -----
module spcr_back (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 en_i,
  input  spcr_pkg::side_t                                      side_i,
  input  logic [spcr_pkg::NumComp-1:0][spcr_pkg::QuotBits-1:0] quot_i,
  input  logic                                                 mode_i,
  input  logic [spcr_pkg::ScalarBits-1:0]                      bounce_i,
  output logic                                                 valid_o,
  output logic [spcr_pkg::VecBits-1:0]                         new_dir_a_o,
  output logic [spcr_pkg::VecBits-1:0]                         new_dir_b_o,
  output logic                                                 collided_o
);

  localparam int Lanes  = spcr_pkg::NumComp;
  localparam int CB     = spcr_pkg::CompBits;
  localparam int DotBits = 2 * CB + 2;
  localparam int PBits  = spcr_pkg::SpeedBits + spcr_pkg::ScalarBits;
  localparam int P8Bits = PBits - 8;
  localparam int KBits  = P8Bits + spcr_pkg::ScalarBits - 8;
  localparam int MBits  = KBits + spcr_pkg::QuotBits;
  localparam int RBits  = MBits - spcr_pkg::NormShift;
  localparam logic [RBits-1:0] PosMax = RBits'((1 << (CB - 1)) - 1);
  localparam logic [RBits-1:0] NegMax = RBits'(1 << (CB - 1));

  // stage B1: dot products for angle mode
  spcr_pkg::side_t              b1_side_q;
  spcr_pkg::quot_t              b1_q_q [Lanes];
  logic signed [DotBits-1:0]    b1_va_q, b1_vb_q, b1_va_d, b1_vb_d;
  // stage B2: speed times mass
  spcr_pkg::side_t              b2_side_q;
  spcr_pkg::quot_t              b2_q_q [Lanes];
  logic                         b2_nega_q, b2_negb_q, b2_nega_d, b2_negb_d;
  logic [P8Bits-1:0]            b2_pa_q, b2_pb_q, b2_pa_d, b2_pb_d;
  // stage B3: bounciness
  spcr_pkg::side_t              b3_side_q;
  spcr_pkg::quot_t              b3_q_q [Lanes];
  logic                         b3_nega_q, b3_negb_q;
  logic [KBits-1:0]             b3_ka_q, b3_kb_q, b3_ka_d, b3_kb_d;
  // output register
  logic                         out_valid_q;
  logic [spcr_pkg::VecBits-1:0] out_a_q, out_b_q, out_a_d, out_b_d;
  logic                         out_hit_q;

  function automatic logic [CB-1:0] sat(input logic [RBits-1:0] m, input logic neg);
    logic [CB-1:0] r;
    if (m == '0) begin
      r = '0;
    end else if (neg) begin
      r = (m > NegMax) ? NegMax[CB-1:0] : CB'(-m);
    end else begin
      r = (m > PosMax) ? PosMax[CB-1:0] : m[CB-1:0];
    end
    return r;
  endfunction

  always_comb begin
    logic signed [DotBits-1:0] nsig;
    b1_va_d = '0;
    b1_vb_d = '0;
    for (int i = 0; i < Lanes; i++) begin
      nsig = side_i.dneg[i] ? -$signed(DotBits'(quot_i[i])) : $signed(DotBits'(quot_i[i]));
      b1_va_d = b1_va_d + $signed(DotBits'(spcr_pkg::comp_mag(side_i.dir_a, i))) * nsig;
      b1_vb_d = b1_vb_d + $signed(DotBits'(spcr_pkg::comp_mag(side_i.dir_b, i))) * nsig;
    end
  end

  always_comb begin
    logic [DotBits-1:0]             ma, mb;
    logic [spcr_pkg::SpeedBits-1:0] spa, spb;
    logic [PBits-1:0]               pa, pb;
    ma = b1_va_q[DotBits-1] ? DotBits'(-b1_va_q) : DotBits'(b1_va_q);
    mb = b1_vb_q[DotBits-1] ? DotBits'(-b1_vb_q) : DotBits'(b1_vb_q);
    if (mode_i) begin
      spa = spcr_pkg::SpeedBits'(ma >> 6);
      spb = spcr_pkg::SpeedBits'(mb >> 6);
      b2_nega_d = b1_va_q[DotBits-1];
      b2_negb_d = !b1_vb_q[DotBits-1];
    end else begin
      spa = spcr_pkg::SpeedBits'(b1_side_q.sp);
      spb = spcr_pkg::SpeedBits'(b1_side_q.sp);
      b2_nega_d = 1'b0;
      b2_negb_d = 1'b1;
    end
    // first particle takes the other's mass
    pa = PBits'(spa) * PBits'(b1_side_q.mass_b);
    pb = PBits'(spb) * PBits'(b1_side_q.mass_a);
    b2_pa_d = mode_i ? P8Bits'(pa >> 8) : P8Bits'(pa >> 9);
    b2_pb_d = mode_i ? P8Bits'(pb >> 8) : P8Bits'(pb >> 9);
  end

  always_comb begin
    logic [P8Bits+spcr_pkg::ScalarBits-1:0] ka, kb;
    ka = (P8Bits+spcr_pkg::ScalarBits)'(b2_pa_q) * (P8Bits+spcr_pkg::ScalarBits)'(bounce_i);
    kb = (P8Bits+spcr_pkg::ScalarBits)'(b2_pb_q) * (P8Bits+spcr_pkg::ScalarBits)'(bounce_i);
    b3_ka_d = KBits'(ka >> 8);
    b3_kb_d = KBits'(kb >> 8);
  end

  always_comb begin
    logic [MBits-1:0] ma, mb;
    for (int i = 0; i < Lanes; i++) begin
      ma = MBits'(b3_ka_q) * MBits'(b3_q_q[i]);
      mb = MBits'(b3_kb_q) * MBits'(b3_q_q[i]);
      out_a_d[i*CB +: CB] = sat(RBits'(ma >> spcr_pkg::NormShift),
                                b3_nega_q ^ b3_side_q.dneg[i]);
      out_b_d[i*CB +: CB] = sat(RBits'(mb >> spcr_pkg::NormShift),
                                b3_negb_q ^ b3_side_q.dneg[i]);
    end
    // no contact: pass velocities through
    if (!b3_side_q.hit) begin
      out_a_d = b3_side_q.dir_a;
      out_b_d = b3_side_q.dir_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_side_q   <= '0;
      b2_side_q   <= '0;
      b3_side_q   <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      b1_side_q   <= side_i;
      b2_side_q   <= b1_side_q;
      b3_side_q   <= b2_side_q;
      out_valid_q <= b3_side_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < Lanes; i++) begin
        b1_q_q[i] <= quot_i[i];
        b2_q_q[i] <= b1_q_q[i];
        b3_q_q[i] <= b2_q_q[i];
      end
      b1_va_q   <= b1_va_d;
      b1_vb_q   <= b1_vb_d;
      b2_nega_q <= b2_nega_d;
      b2_negb_q <= b2_negb_d;
      b2_pa_q   <= b2_pa_d;
      b2_pb_q   <= b2_pb_d;
      b3_nega_q <= b2_nega_q;
      b3_negb_q <= b2_negb_q;
      b3_ka_q   <= b3_ka_d;
      b3_kb_q   <= b3_kb_d;
      out_a_q   <= out_a_d;
      out_b_q   <= out_b_d;
      out_hit_q <= b3_side_q.hit;
    end
  end

  assign valid_o     = out_valid_q;
  assign new_dir_a_o = out_a_q;
  assign new_dir_b_o = out_b_q;
  assign collided_o  = out_hit_q;

endmodule

// ----- design/sphere_pair_collision_response.sv -----
// An accepted pair passes through 2 geometry stages, 25 square-root stages, 15 divider
// stages and 4 scaling stages before its result reaches the master side.
// Throughput: one pair per cycle; the whole pipeline advances together and holds
// while a result waits on the master side.
// Reset clears all valid bits and loads adjustment = 1.0, average mode, bounciness = 1.0.
module sphere_pair_collision_response (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_a, pos_b, dir_a, dir_b, radius_a, radius_b, mass_a, mass_b
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_dir_a, new_dir_b
  output logic [95:0]  m_axis_tdata,
  // collided
  output logic         m_axis_tuser
);

  localparam int VB = spcr_pkg::VecBits;
  localparam int SB = spcr_pkg::ScalarBits;

  logic [SB-1:0] adjustment_q;
  logic          mode_q;
  logic [SB-1:0] bounce_q;
  logic          en;

  spcr_pkg::side_t side_front;
  spcr_pkg::side_t side_mid;
  spcr_pkg::side_t sq_dly_q [spcr_pkg::SqrtStages];
  spcr_pkg::side_t dv_dly_q [spcr_pkg::DivStages];

  logic [spcr_pkg::NumComp-1:0][spcr_pkg::RadBits-1:0]  rad;
  logic [spcr_pkg::NumComp-1:0][spcr_pkg::RootBits-1:0] root;
  logic [spcr_pkg::NumComp-1:0][spcr_pkg::QuotBits-1:0] quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adjustment_q <= SB'(256);
      mode_q       <= 1'b0;
      bounce_q     <= SB'(256);
    end else if (cfg_we_i) begin
      unique case (spcr_pkg::cfg_reg_e'(cfg_index_i))
        spcr_pkg::CfgAdjust: adjustment_q <= cfg_data_i;
        spcr_pkg::CfgMode:   mode_q       <= cfg_data_i[0];
        spcr_pkg::CfgBounce: bounce_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance unless a result is held on the master side
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  spcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (s_axis_tvalid),
    .pos_a_i      (s_axis_tdata[0 +: VB]),
    .pos_b_i      (s_axis_tdata[VB +: VB]),
    .dir_a_i      (s_axis_tdata[2*VB +: VB]),
    .dir_b_i      (s_axis_tdata[3*VB +: VB]),
    .radius_a_i   (s_axis_tdata[4*VB +: SB]),
    .radius_b_i   (s_axis_tdata[4*VB+SB +: SB]),
    .mass_a_i     (s_axis_tdata[4*VB+2*SB +: SB]),
    .mass_b_i     (s_axis_tdata[4*VB+3*SB +: SB]),
    .adjustment_i (adjustment_q),
    .side_o       (side_front),
    .rad_o        (rad)
  );

  spcr_sqrt3 u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad),
    .root_o (root)
  );

  always_comb begin
    side_mid    = sq_dly_q[spcr_pkg::SqrtStages-1];
    side_mid.sp = spcr_pkg::SumBits'(root[1]) + spcr_pkg::SumBits'(root[2]);
  end

  spcr_div3 u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (side_mid.dmag),
    .den_i  (root[0]),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spcr_pkg::SqrtStages; i++) sq_dly_q[i] <= '0;
      for (int i = 0; i < spcr_pkg::DivStages; i++) dv_dly_q[i] <= '0;
    end else if (en) begin
      sq_dly_q[0] <= side_front;
      for (int i = 1; i < spcr_pkg::SqrtStages; i++) sq_dly_q[i] <= sq_dly_q[i-1];
      dv_dly_q[0] <= side_mid;
      for (int i = 1; i < spcr_pkg::DivStages; i++) dv_dly_q[i] <= dv_dly_q[i-1];
    end
  end

  spcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .side_i      (dv_dly_q[spcr_pkg::DivStages-1]),
    .quot_i      (quot),
    .mode_i      (mode_q),
    .bounce_i    (bounce_q),
    .valid_o     (m_axis_tvalid),
    .new_dir_a_o (m_axis_tdata[0 +: VB]),
    .new_dir_b_o (m_axis_tdata[VB +: VB]),
    .collided_o  (m_axis_tuser)
  );

endmodule
